FILE: src/cbp_pkg.sv
// shared types, constants and a helper function of the coefficient buffer packer
package cbp_pkg;

	// buffer geometry
	localparam int MAX_CHANNELS = 4096;
	localparam int CNT_W        = 13;
	localparam int GIDX_W       = CNT_W - 3;
	localparam int GCNT_W       = CNT_W - 2;
	localparam int ADDR_W       = 14;
	localparam int DATA_W       = 32;
	localparam int ZP_W         = 8;

	// stream payload widths
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 48;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_ZP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_BITS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CNT = 2'd3;

	// word slots within one group sequence
	localparam int SLOT_W = 5;
	localparam logic [SLOT_W-1:0] SLOT_B     = 5'd8;
	localparam logic [SLOT_W-1:0] SLOT_C     = 5'd12;
	localparam logic [SLOT_W-1:0] SLOT_S     = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_S_END = 5'd19;
	localparam logic [SLOT_W-1:0] SLOT_FINAL = 5'd20;

	// fixed words
	localparam logic [DATA_W-1:0] C_WORD     = 32'h0010_0010;
	localparam logic [DATA_W-1:0] FINAL_WORD = 32'h0000_1004;

	typedef struct packed {
		logic [ZP_W-1:0]   input_zp;
		logic [ZP_W-1:0]   weight_zp;
		logic [DATA_W-1:0] scale_bits;
		logic [CNT_W-1:0]  channel_count;
	} cfg_t;

	// one classified channel waiting for the back end
	typedef struct packed {
		logic [DATA_W-1:0] a_word;
		logic [GIDX_W-1:0] group;
		logic [2:0]        pos;
		logic              close;
		logic              last;
		logic [GCNT_W-1:0] groups;
	} qent_t;

	// single to half precision, truncating, flush to zero, overflow to infinity
	function automatic logic [15:0] fp16_trunc(logic [31:0] f);
		logic [7:0]  e;
		logic [15:0] r;
		e = f[30:23];
		if (e <= 8'd112) begin
			r = {f[31], 15'd0};
		end else if (e >= 8'd143) begin
			r = {f[31], 5'h1f, 10'd0};
		end else begin
			r = {f[31], 5'(e - 8'd112), f[22:13]};
		end
		return r;
	endfunction

endpackage

FILE: src/cbp_front.sv
// front end: accepts channels, computes the A word and classifies the channel
module cbp_front
	import cbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 q_full,
	output logic                 q_push,
	output qent_t                q_entry
);

	logic [CNT_W-1:0]  chan_idx_q;
	logic [CNT_W-1:0]  count_eff;
	logic [CNT_W-1:0]  idx;
	logic [CNT_W-1:0]  idx_next;
	logic [CNT_W:0]    count_round;
	logic              last;
	logic [8:0]        zp_off;
	logic [DATA_W-1:0] zp_ext;
	logic [DATA_W-1:0] bias;
	logic [DATA_W-1:0] wsum;

	assign bias = s_tdata[31:0];
	assign wsum = s_tdata[63:32];

	// clamp the channel count to the supported range
	always_comb begin
		if (cfg.channel_count == '0) begin
			count_eff = CNT_W'(1);
		end else if (cfg.channel_count > CNT_W'(MAX_CHANNELS)) begin
			count_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = cfg.channel_count;
		end
	end

	// position of this channel, restarting when the count dropped below it
	assign idx         = (chan_idx_q >= count_eff) ? '0 : chan_idx_q;
	assign idx_next    = idx + CNT_W'(1);
	assign last        = (idx_next >= count_eff);
	assign count_round = (CNT_W+1)'(count_eff) + (CNT_W+1)'(7);

	// A = bias - (input_zp - 128) * weight_sum, wrapping
	assign zp_off = $signed({1'b0, cfg.input_zp}) - 9'sd128;
	assign zp_ext = DATA_W'($signed(zp_off));

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_entry.a_word = bias - zp_ext * wsum;
		q_entry.group  = idx[CNT_W-1:3];
		q_entry.pos    = idx[2:0];
		q_entry.last   = last;
		q_entry.close  = last || (idx[2:0] == 3'd7);
		q_entry.groups = count_round[CNT_W:3];
	end

	// channel position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_idx_q <= '0;
		end else if (q_push) begin
			chan_idx_q <= last ? '0 : idx_next;
		end
	end

endmodule

FILE: src/cbp_queue.sv
// short show-ahead queue between front and back
module cbp_queue
	import cbp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_entry,
	output logic  full,
	input  logic  pop,
	output qent_t head,
	output logic  empty
);

	qent_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full  = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: src/cbp_back.sv
// back end: walks the word sequence of each channel into the output register
module cbp_back
	import cbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  qent_t                head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	logic              busy_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_done_q;

	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] end_slot;
	logic              emit;
	logic              final_word;
	logic [ADDR_W-1:0] grp_base;
	logic [ADDR_W-1:0] scale_base;
	logic [ADDR_W-1:0] word_addr;
	logic [DATA_W-1:0] word_data;
	logic [15:0]       b_half;
	logic [15:0]       s_half;

	// current slot and where this entry's sequence ends
	assign slot = busy_q ? slot_q : {2'b00, head.pos};
	always_comb begin
		if (!head.close) begin
			end_slot = {2'b00, head.pos};
		end else if (head.last) begin
			end_slot = SLOT_FINAL;
		end else begin
			end_slot = SLOT_S_END;
		end
	end

	assign emit       = !empty && (!out_valid_q || m_tready);
	assign final_word = (slot == end_slot);
	assign pop        = emit && final_word;

	// word address
	assign grp_base   = ADDR_W'(head.group) << 4;
	assign scale_base = (ADDR_W'(head.groups) << 4) + (ADDR_W'(head.group) << 2);
	always_comb begin
		if (slot == SLOT_FINAL) begin
			word_addr = (ADDR_W'(head.groups) << 4) + (ADDR_W'(head.groups) << 2);
		end else if (slot >= SLOT_S) begin
			word_addr = scale_base + ADDR_W'(slot[1:0]);
		end else begin
			word_addr = grp_base | ADDR_W'(slot[3:0]);
		end
	end

	// word contents
	assign b_half = 16'd128 - {8'd0, cfg.weight_zp};
	assign s_half = fp16_trunc(cfg.scale_bits);
	always_comb begin
		if (slot == SLOT_FINAL) begin
			word_data = FINAL_WORD;
		end else if (slot >= SLOT_S) begin
			word_data = {s_half, s_half};
		end else if (slot >= SLOT_C) begin
			word_data = C_WORD;
		end else if (slot >= SLOT_B) begin
			word_data = {b_half, b_half};
		end else begin
			word_data = head.a_word;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= '0;
		end else if (emit) begin
			busy_q <= !final_word;
			slot_q <= slot + SLOT_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q <= word_addr;
			out_data_q <= word_data;
			out_last_q <= final_word;
			out_done_q <= (slot == SLOT_FINAL);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_data_q, out_addr_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> out_last_q)
		else $error("buffer done word not marked as last of its request");
	a_busy_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !empty)
		else $error("sequencer busy with no queued entry");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> slot_q <= SLOT_FINAL)
		else $error("sequencer slot beyond final word");
	a_final_pops: assert property (@(posedge clk) disable iff (!arst_n)
		emit && slot == SLOT_FINAL |-> pop)
		else $error("final word did not retire its entry");
`endif

endmodule

FILE: src/npu_coefficient_buffer_packer.sv
// top level of the coefficient buffer packer: config registers, front, queue, back
// Each channel passes through the queue and then the output register; the queue accepts further channels
// while earlier words are still emitted. The single output word register emits one word per cycle while
// an entry is queued and m_tready does not stall it; a channel that does not close a group emits only its
// A word; a closing one emits A words up to slot 7, then B, C and S words, and on the last the final word.
// Reset (arst_n low, asynchronous) restores config defaults, position 0 and an empty queue.
module npu_coefficient_buffer_packer
	import cbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // bias[31:0], weight_sum[63:32]
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // word_address[13:0], word_data[45:14], zero pad
	output logic                 m_tlast,  // run_last
	output logic                 m_tuser   // buffer_done
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	qent_t q_entry;
	logic  q_pop;
	qent_t q_head;
	logic  q_empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_zp      <= ZP_W'(128);
			cfg_q.weight_zp     <= ZP_W'(128);
			cfg_q.scale_bits    <= '0;
			cfg_q.channel_count <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INPUT_ZP:    cfg_q.input_zp      <= cfg_data[ZP_W-1:0];
				REG_WEIGHT_ZP:   cfg_q.weight_zp     <= cfg_data[ZP_W-1:0];
				REG_SCALE_BITS:  cfg_q.scale_bits    <= cfg_data;
				REG_CHANNEL_CNT: cfg_q.channel_count <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	cbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	cbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	cbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
